// ===== hdl/pll_divider_search_defines.svh =====
// ----------------------------------------------------------------------------
// PLL divider search assertion macros
// Assertion shorthands used by the top RTL file of the divider search.
// ----------------------------------------------------------------------------
`ifndef PLL_DIVIDER_SEARCH_DEFINES_SVH
`define PLL_DIVIDER_SEARCH_DEFINES_SVH

`ifndef SYNTHESIS
`define PDS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pll divider search: implication check failed");
`define PDS_ASSERT_DELAY(label, clk, rst, ante, lat, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##(lat) (cons)) \
    else $error("pll divider search: latency check failed");
`else
`define PDS_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define PDS_ASSERT_DELAY(label, clk, rst, ante, lat, cons)
`endif

`endif

// ===== hdl/pds_pkg.sv =====
// ----------------------------------------------------------------------------
// PLL divider search package
// Fixed field widths, limits and configuration register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package pds_pkg;

  localparam int TARGET_W = 20;
  localparam int FB_W     = 8;
  localparam int REF_W    = 2;
  localparam int POST_W   = 3;
  localparam int ACT_W    = 23;
  localparam logic [ACT_W-1:0] ACT_LIMIT = 23'h7FFFFF;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK_MIN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK_MAX = 1'b1;

endpackage

`default_nettype wire

// ===== hdl/pds_lane.sv =====
// ----------------------------------------------------------------------------
// PLL divider search candidate lane
// Six-stage pipeline for one fixed divider: feedback value, range check,
// distance to the target and rounded output frequency.
// ----------------------------------------------------------------------------
`default_nettype none

module pds_lane #(
  parameter int REF_CLOCK_KHZ = 25000,
  parameter int DIV = 84,
  parameter int TW = 20,
  parameter int XW = 31,
  parameter int QW = 17,
  parameter int NW = 15
) (
  input  logic                       clk,
  input  logic [TW-1:0]              target,
  input  logic [pds_pkg::FB_W-1:0]   fb_min,
  input  logic [pds_pkg::FB_W-1:0]   fb_max,
  output logic                       ok,
  output logic [NW-1:0]              num,
  output logic [pds_pkg::FB_W-1:0]   fb,
  output logic [pds_pkg::ACT_W-1:0]  act
);

  localparam int FBW = pds_pkg::FB_W;
  localparam int ACTW = pds_pkg::ACT_W;
  localparam longint R = REF_CLOCK_KHZ;
  localparam int TDW = TW + $clog2(DIV + 1);
  localparam longint M = (64'd1 << XW) / (2 * R);
  localparam int MW = $clog2(M + 1);
  localparam int RFW = $clog2(R * 255 + 1);
  localparam int EW = (TDW > RFW) ? TDW : RFW;
  localparam longint YMAX = 2 * R * 255 + DIV;
  localparam int YW = $clog2(YMAX + 1);
  localparam longint MY = (64'd1 << YW) / (2 * DIV);
  localparam int MYW = $clog2(MY + 1);
  localparam int AW = $clog2(YMAX / (2 * DIV) + 2);
  localparam int SW = (AW > ACTW) ? AW : ACTW;

  logic [TDW-1:0]     td_c;
  logic [XW-1:0]      x_c;
  logic [TDW-1:0]     s1_td;
  logic [XW-1:0]      s1_x;
  logic               s1_nz;
  logic [XW+MW-1:0]   s2_px;
  logic [XW-1:0]      s2_x;
  logic [TDW-1:0]     s2_td;
  logic               s2_nz;
  logic [QW-1:0]      qe;
  logic [XW-1:0]      rem;
  logic [QW-1:0]      fbq;
  logic               ok_c;
  logic [FBW-1:0]     s3_fb;
  logic               s3_ok;
  logic [TDW-1:0]     s3_td;
  logic [EW-1:0]      rf;
  logic [EW-1:0]      tdx;
  logic [EW-1:0]      dif;
  logic [YW-1:0]      y_c;
  logic [NW-1:0]      s4_num;
  logic [YW-1:0]      s4_y;
  logic [FBW-1:0]     s4_fb;
  logic               s4_ok;
  logic [YW+MYW-1:0]  s5_py;
  logic [YW-1:0]      s5_y;
  logic [NW-1:0]      s5_num;
  logic [FBW-1:0]     s5_fb;
  logic               s5_ok;
  logic [AW-1:0]      qa;
  logic [YW-1:0]      ra;
  logic [AW-1:0]      aq;
  logic [SW-1:0]      aw;
  logic [ACTW-1:0]    act_c;

  assign td_c = TDW'(target) * TDW'(DIV);
  assign x_c  = XW'({td_c, 1'b0}) + XW'(R);

  assign qe   = QW'(s2_px >> XW);
  assign rem  = s2_x - XW'(qe) * XW'(2 * R);
  assign fbq  = (rem >= XW'(2 * R)) ? qe + QW'(1) : qe;
  assign ok_c = s2_nz && (fbq >= QW'(fb_min)) && (fbq <= QW'(fb_max));

  assign rf  = EW'(R) * EW'(s3_fb);
  assign tdx = EW'(s3_td);
  assign dif = (tdx > rf) ? tdx - rf : rf - tdx;
  assign y_c = YW'(2 * R) * YW'(s3_fb) + YW'(DIV);

  assign qa    = AW'(s5_py >> YW);
  assign ra    = s5_y - YW'(qa) * YW'(2 * DIV);
  assign aq    = (ra >= YW'(2 * DIV)) ? qa + AW'(1) : qa;
  assign aw    = SW'(aq);
  assign act_c = (aw > SW'(pds_pkg::ACT_LIMIT)) ? pds_pkg::ACT_LIMIT : ACTW'(aw);

  always_ff @(posedge clk) begin
    s1_td  <= td_c;
    s1_x   <= x_c;
    s1_nz  <= |target;
    s2_px  <= (XW + MW)'(s1_x) * (XW + MW)'(M);
    s2_x   <= s1_x;
    s2_td  <= s1_td;
    s2_nz  <= s1_nz;
    s3_fb  <= fbq[FBW-1:0];
    s3_ok  <= ok_c;
    s3_td  <= s2_td;
    s4_num <= NW'(dif);
    s4_y   <= y_c;
    s4_fb  <= s3_fb;
    s4_ok  <= s3_ok;
    s5_py  <= (YW + MYW)'(s4_y) * (YW + MYW)'(MY);
    s5_y   <= s4_y;
    s5_num <= s4_num;
    s5_fb  <= s4_fb;
    s5_ok  <= s4_ok;
    ok     <= s5_ok;
    num    <= s5_num;
    fb     <= s5_fb;
    act    <= act_c;
  end

endmodule

`default_nettype wire

// ===== hdl/pll_divider_search.sv =====
// ----------------------------------------------------------------------------
// PLL divider search
// Picks reference, post and feedback dividers that bring a PLL closest to a
// wanted output frequency, one target word per clock while busy is low.
// ----------------------------------------------------------------------------
// Channel   Signals                                   Direction
// config    cfg_we, cfg_index, cfg_data               in
// target    start, busy, target_khz                   in (busy out)
// result    done, found, feedback_div, ref_div,       out
//           post_div_one, post_div_two, actual_khz
//
// A target word is taken on every cycle with start high and busy low.
// Its result word passes through six lane stages, one stage per level
// of the selection tree and the output register.
// Busy is high only during reset and in the cycle after it; there is no clearing pass.
// The result is shown for one cycle on done and cannot be held off.
// ----------------------------------------------------------------------------
`default_nettype none

`include "pll_divider_search_defines.svh"

module pll_divider_search #(
  parameter int REF_DIV_MAX = 2,
  parameter int POST_DIV_MAX = 7,
  parameter int REF_CLOCK_KHZ = 25000
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [pds_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pds_pkg::FB_W-1:0]       cfg_data,
  input  logic                           start,
  input  logic [pds_pkg::TARGET_W-1:0]   target_khz,
  output logic                           busy,
  output logic                           done,
  output logic                           found,
  output logic [pds_pkg::FB_W-1:0]       feedback_div,
  output logic [pds_pkg::REF_W-1:0]      ref_div,
  output logic [pds_pkg::POST_W-1:0]     post_div_one,
  output logic [pds_pkg::POST_W-1:0]     post_div_two,
  output logic [pds_pkg::ACT_W-1:0]      actual_khz
);

  localparam int TW = pds_pkg::TARGET_W;
  localparam int FBW = pds_pkg::FB_W;
  localparam int ACTW = pds_pkg::ACT_W;
  localparam int RDW = pds_pkg::REF_W;
  localparam int PDW = pds_pkg::POST_W;
  localparam int NC = REF_DIV_MAX * (POST_DIV_MAX * (POST_DIV_MAX - 1) / 2);
  localparam int DMAX = REF_DIV_MAX * POST_DIV_MAX * (POST_DIV_MAX - 1);
  localparam int DW = $clog2(DMAX + 1);
  localparam longint XMAX = 2 * ((64'd1 << TW) - 1) * DMAX + REF_CLOCK_KHZ;
  localparam int XW = $clog2(XMAX + 1);
  localparam int QW0 = $clog2(XMAX / (2 * REF_CLOCK_KHZ) + 2);
  localparam int QW = (QW0 > FBW) ? QW0 : FBW + 1;
  localparam int NW = $clog2(REF_CLOCK_KHZ + 1);
  localparam int RW = $clog2(REF_DIV_MAX + 1);
  localparam int PW = $clog2(POST_DIV_MAX + 1);
  localparam int PRW = $clog2(POST_DIV_MAX * (POST_DIV_MAX - 1) + 1);
  localparam int LVL = (NC > 1) ? $clog2(NC) : 1;
  localparam int NP = 1 << LVL;
  localparam int LAT = 6 + LVL + 1;

  typedef struct packed {
    logic            v;
    logic [NW-1:0]   num;
    logic [DW-1:0]   d;
    logic [FBW-1:0]  fb;
    logic [RW-1:0]   rf;
    logic [PW-1:0]   p1;
    logic [PW-1:0]   p2;
    logic [PRW-1:0]  prod;
    logic [ACTW-1:0] act;
  } cand_t;

  // Candidate k in sweep order, packed as ref * 65536 + post1 * 256 + post2.
  function automatic int cand_code(int k);
    int n;
    n = 0;
    cand_code = 0;
    for (int r = REF_DIV_MAX; r >= 1; r--) begin
      for (int a = POST_DIV_MAX; a >= 1; a--) begin
        for (int b = POST_DIV_MAX; b >= 1; b--) begin
          if (a > b) begin
            if (n == k) begin
              cand_code = r * 65536 + a * 256 + b;
            end
            n++;
          end
        end
      end
    end
  endfunction

  // The earlier candidate a is kept unless b is strictly better.
  function automatic cand_t pick(cand_t a, cand_t b);
    logic [NW+DW-1:0]  lhs;
    logic [NW+DW-1:0]  rhs;
    logic [FBW+RW-1:0] va;
    logic [FBW+RW-1:0] vb;
    logic              take;
    lhs  = (NW + DW)'(b.num) * (NW + DW)'(a.d);
    rhs  = (NW + DW)'(a.num) * (NW + DW)'(b.d);
    va   = (FBW + RW)'(b.fb) * (FBW + RW)'(a.rf);
    vb   = (FBW + RW)'(a.fb) * (FBW + RW)'(b.rf);
    take = b.v && (!a.v || (lhs < rhs) ||
           ((lhs == rhs) && ((va < vb) || ((va == vb) && (b.prod < a.prod)))));
    pick = take ? b : a;
  endfunction

  logic [FBW-1:0] fb_min;
  logic [FBW-1:0] fb_max;
  logic           accept;
  logic [LAT-1:0] vpipe;
  cand_t          leaf [NP];
  cand_t          node [NP-1];
  cand_t          root;

  assign accept = start && !busy;
  assign root   = node[0];
  assign done   = vpipe[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b1;
      fb_min <= '0;
      fb_max <= '1;
      vpipe  <= '0;
    end else begin
      busy  <= 1'b0;
      vpipe <= {vpipe[LAT-2:0], accept};
      if (cfg_we) begin
        case (cfg_index)
          pds_pkg::CFG_FEEDBACK_MIN: fb_min <= cfg_data;
          pds_pkg::CFG_FEEDBACK_MAX: fb_max <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  for (genvar j = 0; j < NP; j++) begin : g_lane
    if (j < NC) begin : g_real
      localparam int CODE = cand_code(j);
      localparam int CR = CODE / 65536;
      localparam int CP1 = (CODE / 256) % 256;
      localparam int CP2 = CODE % 256;
      localparam int CD = CR * CP1 * CP2;
      logic             l_ok;
      logic [NW-1:0]    l_num;
      logic [FBW-1:0]   l_fb;
      logic [ACTW-1:0]  l_act;

      pds_lane #(
        .REF_CLOCK_KHZ(REF_CLOCK_KHZ),
        .DIV(CD),
        .TW(TW),
        .XW(XW),
        .QW(QW),
        .NW(NW)
      ) u_lane (
        .clk(clk),
        .target(target_khz),
        .fb_min(fb_min),
        .fb_max(fb_max),
        .ok(l_ok),
        .num(l_num),
        .fb(l_fb),
        .act(l_act)
      );

      assign leaf[j] = '{v: l_ok, num: l_num, d: DW'(CD), fb: l_fb, rf: RW'(CR),
                         p1: PW'(CP1), p2: PW'(CP2), prod: PRW'(CP1 * CP2),
                         act: l_act};
    end else begin : g_pad
      assign leaf[j] = '0;
    end
  end

  for (genvar i = 0; i < NP - 1; i++) begin : g_node
    if (2 * i + 2 < NP - 1) begin : g_inner
      always_ff @(posedge clk) begin
        node[i] <= pick(node[2*i+1], node[2*i+2]);
      end
    end else begin : g_bottom
      always_ff @(posedge clk) begin
        node[i] <= pick(leaf[2*i+1-(NP-1)], leaf[2*i+2-(NP-1)]);
      end
    end
  end

  always_ff @(posedge clk) begin
    found        <= root.v;
    feedback_div <= root.v ? root.fb : '0;
    ref_div      <= root.v ? RDW'(root.rf) : '0;
    post_div_one <= root.v ? PDW'(root.p1) : '0;
    post_div_two <= root.v ? PDW'(root.p2) : '0;
    actual_khz   <= root.v ? root.act : '0;
  end

  `PDS_ASSERT_DELAY(a_latency, clk, rst, accept, LAT, done)
  `PDS_ASSERT_IMPLY(a_fb_range, clk, rst, done && found,
    (feedback_div >= fb_min) && (feedback_div <= fb_max))
  `PDS_ASSERT_IMPLY(a_post_order, clk, rst, done && found, post_div_one > post_div_two)
  `PDS_ASSERT_IMPLY(a_ref_set, clk, rst, done && found, ref_div != '0)

endmodule

`default_nettype wire
